// File: hw/rtl/md5_pkg.sv
// shared constants, types and helper functions for the md5 digest engine
package md5_pkg;

    localparam int unsigned CountWidth = 61;
    localparam int unsigned LenWidth   = 64;

    localparam logic [31:0] MD5_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_SHIFT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE  = 8'h00;
    localparam logic [5:0] PAD_LEN_MARK   = 6'd56;
    localparam logic [5:0] BLOCK_LAST     = 6'h3f;
    localparam logic [1:0] WORD_LAST      = 2'd3;
    localparam logic [2:0] LEN_BYTE_LAST  = 3'd7;
    localparam logic [6:0] STEP_LAST      = 7'd64;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } md5_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_EMIT
    } md5_state_t;

    // message word used by a compression step
    function automatic logic [3:0] md5_widx(input logic [5:0] step);
        logic [3:0] s;
        s = step[3:0];
        unique case (step[5:4])
            2'd0:    md5_widx = s;
            2'd1:    md5_widx = 4'((s << 2) + s + 4'd1);
            2'd2:    md5_widx = 4'((s << 1) + s + 4'd5);
            default: md5_widx = 4'((s << 3) - s);
        endcase
    endfunction

    // round function
    function automatic logic [31:0] md5_f(input logic [1:0] round,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
        unique case (round)
            2'd0:    md5_f = (b & c) | (d & ~b);
            2'd1:    md5_f = (b & d) | (c & ~d);
            2'd2:    md5_f = b ^ c ^ d;
            default: md5_f = c ^ (b | ~d);
        endcase
    endfunction

endpackage

// File: hw/rtl/md5_ram.sv
// generic single-write, single-read synchronous ram with registered read
module md5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/md5_message_digest.sv
// md5 digest engine top level: byte intake, padding sequencer and compression rounds
//
// input channel s_*: one item per handshake. s_tuser is the command (0 absorb,
// 1 finish), s_tdata carries the message byte and is ignored on finish.
// the byte of an absorb item is gathered into a 32-bit word, and every
// fourth byte is written to the 16-word block ram. after every 64th byte
// the 64 compression steps run, one step a cycle, each fed by a registered
// read of the block ram, plus a fold step; s_tready is low throughout, so
// no new byte is taken until the compression and its fold are done.
// a finish item starts the padding sequencer, which pushes 0x80, zeros and
// the 8 length bytes through the same byte path (paused by one or two
// compressions), then offers the four digest words on m_* in order
// A, B, C, D; m_tuser holds the word index and m_tlast marks word D.
// if the receiver stalls, the current word simply holds; no new item is
// taken until all four words are delivered. after word D the chaining
// words and byte count return to their initial values.
// reset (aresetn low, synchronous) restores the initial chaining words and
// clears the byte count; the block ram needs no clearing since every word
// is rewritten before a compression reads it.
module md5_message_digest
    import md5_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] command
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [1:0]  m_tuser,   // [1:0] word_index
    output logic        m_tlast    // last_word
);

    // control and working registers
    md5_state_t            state_reg, state_next;
    md5_state_t            ret_reg, ret_next;      // where to go after a compression
    logic [6:0]            step_reg, step_next;    // 0 primes the first read
    logic [CountWidth-1:0] count_reg, count_next;  // message byte count
    logic [31:0]           h_reg [4];
    logic [31:0]           h_next [4];
    logic [31:0]           a_reg, a_next, b_reg, b_next;
    logic [31:0]           c_reg, c_next, d_reg, d_next;
    logic [31:0]           gather_reg, gather_next; // partial little-endian word
    logic [LenWidth-1:0]   len_reg, len_next;      // bit length, shifted out bytewise
    logic [2:0]            len_cnt_reg, len_cnt_next;
    logic [1:0]            out_idx_reg, out_idx_next;

    // byte path
    logic                  absorb_en;
    logic [7:0]            absorb_byte;
    md5_state_t            nominal;   // state after this byte if no block completes

    // block ram
    logic                  ram_we;
    logic [3:0]            ram_waddr;
    logic [31:0]           ram_wdata;
    logic [3:0]            ram_raddr;
    logic [31:0]           ram_rdata;

    // compression step datapath
    logic [5:0]            cur_step;
    logic [31:0]           step_f;
    logic [31:0]           step_t;
    logic [4:0]            step_sh;
    logic [63:0]           step_dbl;
    logic [31:0]           step_rot;

    md5_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // step s is computed while the read for step s+1 is issued
    assign cur_step  = 6'(step_reg - 7'd1);
    assign ram_raddr = md5_widx(step_reg[5:0]);
    assign step_f    = md5_f(cur_step[5:4], b_reg, c_reg, d_reg);
    assign step_t    = a_reg + step_f + ram_rdata + MD5_K[cur_step];
    assign step_sh   = MD5_SHIFT[{cur_step[5:4], cur_step[1:0]}];
    // rotate left through a doubled word; the shift is never zero here
    assign step_dbl  = {step_t, step_t} >> (6'd32 - {1'b0, step_sh});
    assign step_rot  = step_dbl[31:0];

    // a full word goes to the ram when its fourth byte arrives
    assign ram_wdata = {absorb_byte, gather_reg[31:8]};
    assign ram_waddr = count_reg[5:2];
    assign ram_we    = absorb_en && (count_reg[1:0] == 2'd3);

    // digest word out
    assign m_tdata = h_reg[out_idx_reg];
    assign m_tuser = out_idx_reg;
    assign m_tlast = (out_idx_reg == WORD_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            len_cnt_reg <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                h_reg[i] <= MD5_INIT[i];
            end
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            len_cnt_reg <= len_cnt_next;
            out_idx_reg <= out_idx_next;
            for (int i = 0; i < 4; i++) begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        gather_reg <= gather_next;
        len_reg    <= len_next;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        len_cnt_next = len_cnt_reg;
        out_idx_next = out_idx_reg;
        h_next       = h_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        gather_next  = gather_reg;
        len_next     = len_reg;
        absorb_en    = 1'b0;
        absorb_byte  = PAD_ZERO_BYTE;
        nominal      = state_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (md5_cmd_t'(s_tuser) == CMD_FINISH) begin
                        // bit length is the byte count times eight, modulo 2^64
                        len_next     = {count_reg, 3'b000};
                        len_cnt_next = '0;
                        state_next   = ST_PAD_ONE;
                    end else begin
                        absorb_en   = 1'b1;
                        absorb_byte = s_tdata;
                        nominal     = ST_IDLE;
                    end
                end
            end
            ST_PAD_ONE: begin
                absorb_en   = 1'b1;
                absorb_byte = PAD_FIRST_BYTE;
                nominal     = ST_PAD_ZERO;
            end
            ST_PAD_ZERO: begin
                if (count_reg[5:0] == PAD_LEN_MARK) begin
                    state_next = ST_LEN;
                end else begin
                    absorb_en   = 1'b1;
                    absorb_byte = PAD_ZERO_BYTE;
                    nominal     = ST_PAD_ZERO;
                end
            end
            ST_LEN: begin
                absorb_en    = 1'b1;
                absorb_byte  = len_reg[7:0];
                len_next     = len_reg >> 8;
                len_cnt_next = len_cnt_reg + 3'd1;
                nominal      = (len_cnt_reg == LEN_BYTE_LAST) ? ST_EMIT : ST_LEN;
            end
            ST_COMP: begin
                step_next = step_reg + 7'd1;
                if (step_reg != '0) begin
                    a_next = d_reg;
                    d_next = c_reg;
                    c_next = b_reg;
                    b_next = b_reg + step_rot;
                end
                if (step_reg == STEP_LAST) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                state_next = ret_reg;
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    out_idx_next = out_idx_reg + 2'd1;
                    if (out_idx_reg == WORD_LAST) begin
                        // back to the initial state for the next message
                        for (int i = 0; i < 4; i++) begin
                            h_next[i] = MD5_INIT[i];
                        end
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // shared byte path: gather, count, and start a compression on a full block
        if (absorb_en) begin
            gather_next = {absorb_byte, gather_reg[31:8]};
            count_next  = count_reg + CountWidth'(1);
            if (count_reg[5:0] == BLOCK_LAST) begin
                state_next = ST_COMP;
                ret_next   = nominal;
                step_next  = '0;
                a_next     = h_reg[0];
                b_next     = h_reg[1];
                c_next     = h_reg[2];
                d_next     = h_reg[3];
            end else begin
                state_next = nominal;
            end
        end
    end

    // input and output never open at the same time
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result channels both active");

    // the block ram is only read, never written, while compressing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COMP || state_reg == ST_FOLD) |-> !ram_we)
        else $error("block ram written during compression");

    // a compression starts only on a block boundary
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMP && state_next == ST_COMP) |=> (count_reg[5:0] == '0))
        else $error("compression started mid-block");

    // after the last digest word the byte count is back to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (count_reg == '0 && s_tready))
        else $error("message state not restored after digest");

endmodule
